FILE: hdl/sfd_pkg.sv
// sfd_pkg: shared types and constants for the slip frame decoder
// holds event kinds, register indexes, reset values and the config struct
// no dependencies
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int SFD_MAX_FRAME_DEF = 256;

  localparam int SFD_BYTE_W  = 8;
  localparam int SFD_INDEX_W = 9;
  localparam int SFD_ADDR_W  = 5;
  localparam int SFD_DATA_W  = 32;

  typedef enum logic [2:0] {
    EV_DATA     = 3'd0,
    EV_START    = 3'd1,
    EV_END      = 3'd2,
    EV_BADESC   = 3'd3,
    EV_OVERFLOW = 3'd4
  } sfd_event_t;

  localparam logic [2:0] REG_START_CODE      = 3'd0;
  localparam logic [2:0] REG_END_CODE        = 3'd1;
  localparam logic [2:0] REG_ESCAPE_CODE     = 3'd2;
  localparam logic [2:0] REG_ESC_END_CODE    = 3'd3;
  localparam logic [2:0] REG_ESC_ESCAPE_CODE = 3'd4;
  localparam logic [2:0] REG_ESC_START_CODE  = 3'd5;

  localparam logic [7:0] RST_START_CODE      = 8'd171;
  localparam logic [7:0] RST_END_CODE        = 8'd192;
  localparam logic [7:0] RST_ESCAPE_CODE     = 8'd219;
  localparam logic [7:0] RST_ESC_END_CODE    = 8'd220;
  localparam logic [7:0] RST_ESC_ESCAPE_CODE = 8'd221;
  localparam logic [7:0] RST_ESC_START_CODE  = 8'd222;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] escape_code;
    logic [7:0] escaped_end_code;
    logic [7:0] escaped_escape_code;
    logic [7:0] escaped_start_code;
  } sfd_cfg_t;

endpackage

FILE: hdl/slip_frame_decoder.sv
// slip_frame_decoder: an accepted byte is held in the input register, then its result in the result register
// throughput one byte per cycle while out_tready takes each result; set by the input register and result register pair
// an escape byte produces no result and leaves the result register untouched
// rst_n synchronous active low: codes return to defaults, escape flag and length clear
// depends on sfd_pkg and sfd_regs
`timescale 1ns / 1ps

module slip_frame_decoder
  import sfd_pkg::*;
#(
  parameter int MAX_FRAME = SFD_MAX_FRAME_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [SFD_ADDR_W-1:0] cfg_paddr,
  input  logic [SFD_DATA_W-1:0] cfg_pwdata,
  output logic [SFD_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] raw_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // [7:0] data_byte, [16:8] byte_index, [23:17] zero
  output logic [2:0]            out_tuser   // [2:0] event_kind
);

  localparam int FCW = $clog2(MAX_FRAME + 1);

  sfd_cfg_t cfg;

  sfd_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  logic                   stg_valid_r;
  logic [SFD_BYTE_W-1:0]  stg_byte_r;
  logic                   pend_r, pend_nxt;
  logic [FCW-1:0]         fc_r, fc_nxt;
  logic                   out_valid_r;
  sfd_event_t             out_kind_r, kind_nxt;
  logic [SFD_BYTE_W-1:0]  out_data_r, data_nxt;
  logic [SFD_INDEX_W-1:0] out_index_r, index_nxt;

  logic                         has_res;
  logic                         store;
  logic [SFD_BYTE_W-1:0]        store_val;
  logic                         adv;
  logic [FCW+SFD_INDEX_W-1:0]   fc_ext;
  logic [SFD_INDEX_W-1:0]       fc_idx;
  logic [FCW+SFD_INDEX_W-1:0]   max_ext;
  logic [SFD_INDEX_W-1:0]       max_idx;

  assign fc_ext  = {{SFD_INDEX_W{1'b0}}, fc_r};
  assign fc_idx  = fc_ext[SFD_INDEX_W-1:0];
  assign max_ext = {{SFD_INDEX_W{1'b0}}, FCW'(MAX_FRAME)};
  assign max_idx = max_ext[SFD_INDEX_W-1:0];

  always_comb begin
    has_res   = 1'b0;
    store     = 1'b0;
    store_val = '0;
    kind_nxt  = EV_DATA;
    data_nxt  = '0;
    index_nxt = fc_idx;
    pend_nxt  = pend_r;
    fc_nxt    = fc_r;
    if (pend_r) begin
      pend_nxt = 1'b0;
      has_res  = 1'b1;
      if (stg_byte_r == cfg.escaped_end_code) begin
        store     = 1'b1;
        store_val = cfg.end_code;
      end else if (stg_byte_r == cfg.escaped_escape_code) begin
        store     = 1'b1;
        store_val = cfg.escape_code;
      end else if (stg_byte_r == cfg.escaped_start_code) begin
        store     = 1'b1;
        store_val = cfg.start_code;
      end else begin
        kind_nxt = EV_BADESC;
      end
    end else if (stg_byte_r == cfg.start_code) begin
      has_res   = 1'b1;
      fc_nxt    = '0;
      kind_nxt  = EV_START;
      index_nxt = '0;
    end else if (stg_byte_r == cfg.end_code) begin
      has_res  = 1'b1;
      kind_nxt = EV_END;
    end else if (stg_byte_r == cfg.escape_code) begin
      pend_nxt = 1'b1;
    end else begin
      has_res   = 1'b1;
      store     = 1'b1;
      store_val = stg_byte_r;
    end
    if (store) begin
      if (fc_r < FCW'(MAX_FRAME)) begin
        kind_nxt = EV_DATA;
        data_nxt = store_val;
        fc_nxt   = fc_r + FCW'(1);
      end else begin
        kind_nxt = EV_OVERFLOW;
      end
    end
  end

  assign adv       = stg_valid_r & (~has_res | ~out_valid_r | out_tready);
  assign in_tready = ~stg_valid_r | adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      fc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        stg_valid_r <= in_tvalid;
      end
      if (adv) begin
        pend_r <= pend_nxt;
        fc_r   <= fc_nxt;
      end
      if (adv && has_res) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_byte_r <= in_tdata;
    end
    if (adv && has_res) begin
      out_kind_r  <= kind_nxt;
      out_data_r  <= data_nxt;
      out_index_r <= index_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_index_r, out_data_r};
  assign out_tuser  = out_kind_r;

  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= FCW'(MAX_FRAME))
    else $error("frame length beyond limit");

  a_ovf_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == EV_OVERFLOW |-> out_index_r == max_idx && out_data_r == '0)
    else $error("overflow result with wrong index or data");

  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == EV_START |-> out_index_r == '0 && out_data_r == '0)
    else $error("start result not zeroed");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !pend_r && stg_byte_r == cfg.start_code |=> fc_r == '0 && !pend_r)
    else $error("start code did not restart frame");

  a_esc_silent: assert property (@(posedge clk) disable iff (!rst_n)
    adv && pend_nxt |=> pend_r && $stable(out_kind_r) && $stable(out_index_r))
    else $error("escape byte disturbed result register");

endmodule

FILE: hdl/sfd_regs.sv
// sfd_regs: apb-style register file holding the framing codes
// depends on sfd_pkg for register indexes, reset values and sfd_cfg_t
`timescale 1ns / 1ps

module sfd_regs
  import sfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [SFD_ADDR_W-1:0] cfg_paddr,
  input  logic [SFD_DATA_W-1:0] cfg_pwdata,
  output logic [SFD_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output sfd_cfg_t              cfg
);

  sfd_cfg_t   cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;
  logic [7:0] rd_byte;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[SFD_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code          <= RST_START_CODE;
      cfg_r.end_code            <= RST_END_CODE;
      cfg_r.escape_code         <= RST_ESCAPE_CODE;
      cfg_r.escaped_end_code    <= RST_ESC_END_CODE;
      cfg_r.escaped_escape_code <= RST_ESC_ESCAPE_CODE;
      cfg_r.escaped_start_code  <= RST_ESC_START_CODE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_START_CODE:      cfg_r.start_code          <= cfg_pwdata[7:0];
        REG_END_CODE:        cfg_r.end_code            <= cfg_pwdata[7:0];
        REG_ESCAPE_CODE:     cfg_r.escape_code         <= cfg_pwdata[7:0];
        REG_ESC_END_CODE:    cfg_r.escaped_end_code    <= cfg_pwdata[7:0];
        REG_ESC_ESCAPE_CODE: cfg_r.escaped_escape_code <= cfg_pwdata[7:0];
        REG_ESC_START_CODE:  cfg_r.escaped_start_code  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START_CODE:      rd_byte = cfg_r.start_code;
      REG_END_CODE:        rd_byte = cfg_r.end_code;
      REG_ESCAPE_CODE:     rd_byte = cfg_r.escape_code;
      REG_ESC_END_CODE:    rd_byte = cfg_r.escaped_end_code;
      REG_ESC_ESCAPE_CODE: rd_byte = cfg_r.escaped_escape_code;
      REG_ESC_START_CODE:  rd_byte = cfg_r.escaped_start_code;
      default:             rd_byte = 8'd0;
    endcase
  end

  assign cfg_prdata = {{(SFD_DATA_W-8){1'b0}}, rd_byte};
  assign cfg       = cfg_r;

endmodule

FILE: bench/sfd_event_checker.sv
// sfd_event_checker: watches the request and event streams of slip_frame_decoder
// keeps its own copy of the codes from register writes and the frame state, predicts each event
// and compares in order; depends on sfd_pkg
`timescale 1ns / 1ps

module sfd_event_checker
  import sfd_pkg::*;
#(
  parameter int MAX_FRAME = SFD_MAX_FRAME_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [SFD_ADDR_W-1:0] cfg_paddr,
  input  logic [SFD_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] raw_byte
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [23:0]           out_tdata,  // [7:0] data_byte, [16:8] byte_index, [23:17] zero
  input  logic [2:0]            out_tuser,  // [2:0] event_kind
  output int                    errors,
  output int                    pending,
  output int                    n_checked,
  output int                    n_ends,
  output int                    n_badesc,
  output int                    n_overflow
);

  typedef struct packed {
    sfd_event_t kind;
    logic [7:0] data;
    logic [8:0] index;
  } frame_event_t;

  frame_event_t expected_events[$];
  sfd_cfg_t     codes;
  logic         esc_armed;
  int           frame_len;

  function automatic void add_event(input sfd_event_t kind, input logic [7:0] data,
                                    input int idx);
    frame_event_t ev;
    ev.kind  = kind;
    ev.data  = data;
    ev.index = 9'(idx);
    expected_events.push_back(ev);
  endfunction

  function automatic void store_byte(input logic [7:0] value);
    if (frame_len < MAX_FRAME) begin
      add_event(EV_DATA, value, frame_len);
      frame_len++;
    end else begin
      add_event(EV_OVERFLOW, 8'd0, frame_len);
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    if (esc_armed) begin
      // the byte after an escape is always the second half of the pair
      esc_armed = 1'b0;
      if (b == codes.escaped_end_code) begin
        store_byte(codes.end_code);
      end else if (b == codes.escaped_escape_code) begin
        store_byte(codes.escape_code);
      end else if (b == codes.escaped_start_code) begin
        store_byte(codes.start_code);
      end else begin
        add_event(EV_BADESC, 8'd0, frame_len);
      end
    end else if (b == codes.start_code) begin
      frame_len = 0;
      add_event(EV_START, 8'd0, 0);
    end else if (b == codes.end_code) begin
      add_event(EV_END, 8'd0, frame_len);
    end else if (b == codes.escape_code) begin
      esc_armed = 1'b1;
    end else begin
      store_byte(b);
    end
  endfunction

  always @(posedge clk) begin : watch
    frame_event_t want;
    if (!rst_n) begin
      codes = '{RST_START_CODE, RST_END_CODE, RST_ESCAPE_CODE,
                RST_ESC_END_CODE, RST_ESC_ESCAPE_CODE, RST_ESC_START_CODE};
      esc_armed  = 1'b0;
      frame_len  = 0;
      expected_events.delete();
      errors     = 0;
      n_checked  = 0;
      n_ends     = 0;
      n_badesc   = 0;
      n_overflow = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_START_CODE:      codes.start_code          = cfg_pwdata[7:0];
          REG_END_CODE:        codes.end_code            = cfg_pwdata[7:0];
          REG_ESCAPE_CODE:     codes.escape_code         = cfg_pwdata[7:0];
          REG_ESC_END_CODE:    codes.escaped_end_code    = cfg_pwdata[7:0];
          REG_ESC_ESCAPE_CODE: codes.escaped_escape_code = cfg_pwdata[7:0];
          REG_ESC_START_CODE:  codes.escaped_start_code  = cfg_pwdata[7:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event: expected none, got kind %0d data %02h index %0d",
                   $time, out_tuser, out_tdata[7:0], out_tdata[16:8]);
          errors++;
        end else begin
          want = expected_events.pop_front();
          n_checked++;
          case (want.kind)
            EV_END:      n_ends++;
            EV_BADESC:   n_badesc++;
            EV_OVERFLOW: n_overflow++;
            default: ;
          endcase
          if (out_tuser !== want.kind || out_tdata[7:0] !== want.data ||
              out_tdata[16:8] !== want.index) begin
            $display({"%0t: event mismatch: expected kind %0d data %02h index %0d,",
                      " got kind %0d data %02h index %0d"},
                     $time, want.kind, want.data, want.index,
                     out_tuser, out_tdata[7:0], out_tdata[16:8]);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready)
        decode_byte(in_tdata);
    end
    pending <= expected_events.size();
  end

endmodule

FILE: bench/tb_top.sv
// tb_top: drives slip_frame_decoder with framed, escaped and noisy byte streams
// under several code settings and flow-control mixes, then gives the verdict
// depends on sfd_pkg, slip_frame_decoder and sfd_event_checker
`timescale 1ns / 1ps

module tb_top
  import sfd_pkg::*;
();

  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 40;
  localparam logic [2:0] REG_UNUSED = 3'd6;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [SFD_ADDR_W-1:0] cfg_paddr = '0;
  logic [SFD_DATA_W-1:0] cfg_pwdata = '0;
  logic [SFD_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;
  logic [2:0]            out_tuser;

  int errors, pending, n_checked, n_ends, n_badesc, n_overflow;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int bytes_sent     = 0;
  int cycles         = 0;

  sfd_cfg_t codes_now = '{RST_START_CODE, RST_END_CODE, RST_ESCAPE_CODE,
                          RST_ESC_END_CODE, RST_ESC_ESCAPE_CODE, RST_ESC_START_CODE};

  sfd_cfg_t code_sets[PHASES] = '{
    '{RST_START_CODE, RST_END_CODE, RST_ESCAPE_CODE,
      RST_ESC_END_CODE, RST_ESC_ESCAPE_CODE, RST_ESC_START_CODE},
    '{8'h00, 8'hff, 8'h01, 8'h00, 8'hff, 8'h01},
    '{8'hff, 8'h00, 8'hfe, 8'hff, 8'h00, 8'hfe},
    '{8'h7e, 8'h7e, 8'h7d, 8'h5e, 8'h5e, 8'h5e},
    '{8'h10, 8'h20, 8'h20, 8'h30, 8'h31, 8'h32},
    '{8'h80, 8'h40, 8'h00, 8'h01, 8'h02, 8'hff},
    '{8'h01, 8'h02, 8'hff, 8'hfe, 8'hfd, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{RST_START_CODE, RST_END_CODE, RST_ESCAPE_CODE,
      RST_ESC_END_CODE, RST_ESC_ESCAPE_CODE, RST_ESC_START_CODE}
  };

  // end without start, data before start, all pair kinds, bad pairs, end, continued count
  logic [7:0] directed_bytes[20] = '{
    RST_END_CODE, 8'h00, RST_START_CODE, 8'h00, 8'hff,
    RST_ESCAPE_CODE, RST_ESC_END_CODE, RST_ESCAPE_CODE, RST_ESC_ESCAPE_CODE,
    RST_ESCAPE_CODE, RST_ESC_START_CODE, RST_ESCAPE_CODE, RST_START_CODE,
    RST_ESCAPE_CODE, RST_ESCAPE_CODE, RST_ESCAPE_CODE, RST_END_CODE,
    RST_END_CODE, 8'h55, 8'haa
  };

  slip_frame_decoder u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  sfd_event_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .errors      (errors),
    .pending     (pending),
    .n_checked   (n_checked),
    .n_ends      (n_ends),
    .n_badesc    (n_badesc),
    .n_overflow  (n_overflow)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // hold off requests until every predicted event has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [7:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
  endtask

  task automatic load_codes(input sfd_cfg_t c);
    reg_write(REG_START_CODE, c.start_code);
    reg_write(REG_END_CODE, c.end_code);
    reg_write(REG_ESCAPE_CODE, c.escape_code);
    reg_write(REG_ESC_END_CODE, c.escaped_end_code);
    reg_write(REG_ESC_ESCAPE_CODE, c.escaped_escape_code);
    reg_write(REG_ESC_START_CODE, c.escaped_start_code);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    codes_now = c;
  endtask

  task automatic send_frame(input int len);
    logic [7:0] b;
    send_byte(codes_now.start_code);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      if ($urandom_range(39) == 0) begin
        // broken pair
        send_byte(codes_now.escape_code);
        send_byte(b);
      end else if (b == codes_now.start_code) begin
        send_byte(codes_now.escape_code);
        send_byte(codes_now.escaped_start_code);
      end else if (b == codes_now.end_code) begin
        send_byte(codes_now.escape_code);
        send_byte(codes_now.escaped_end_code);
      end else if (b == codes_now.escape_code) begin
        send_byte(codes_now.escape_code);
        send_byte(codes_now.escaped_escape_code);
      end else begin
        send_byte(b);
      end
    end
    if ($urandom_range(15) != 0)
      send_byte(codes_now.end_code);
  endtask

  initial begin
    int phase_goal;
    int pause_at;
    bit paused;
    sfd_cfg_t c;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_bytes[i])
      send_byte(directed_bytes[i]);

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        wait_idle();
        repeat (4) @(posedge clk);
        if (p == 1)
          reg_write(REG_UNUSED, 8'h5a);
        c = code_sets[p];
        if (p == 7) begin
          c.start_code          = 8'($urandom_range(255));
          c.end_code            = 8'($urandom_range(255));
          c.escape_code         = 8'($urandom_range(255));
          c.escaped_end_code    = 8'($urandom_range(255));
          c.escaped_escape_code = 8'($urandom_range(255));
          c.escaped_start_code  = 8'($urandom_range(255));
        end
        load_codes(c);
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase

      // long frame runs past the limit, then pairs and plain bytes on the full count
      if (p == 1 || p == 5) begin
        send_frame($urandom_range(270, 290));
        send_byte(codes_now.escape_code);
        send_byte(codes_now.escaped_end_code);
        send_byte(codes_now.escape_code);
        send_byte(8'($urandom_range(255)));
        send_byte(8'($urandom_range(255)));
      end

      phase_goal = bytes_sent + ITEMS_PER_PHASE;
      pause_at   = bytes_sent + $urandom_range(10, ITEMS_PER_PHASE - 10);
      paused     = 1'b0;
      while (bytes_sent < phase_goal) begin
        case ($urandom_range(9))
          0: send_byte(8'($urandom_range(255)));
          1: begin
            send_byte(codes_now.escape_code);
            send_byte(8'($urandom_range(255)));
          end
          default: send_frame($urandom_range(0, 24));
        endcase
        if (!paused && bytes_sent >= pause_at) begin
          wait_idle();
          paused = 1'b1;
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);

    $display("%0d bytes sent, %0d events checked: %0d frame ends, %0d bad escapes,",
             bytes_sent, n_checked, n_ends, n_badesc);
    $display("%0d overflows over %0d code settings incl. equal and extreme codes, with stalls",
             n_overflow, PHASES);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
